### rtl/core/npcs_pkg.sv
// Shared types, constants and codes for the nearest palette colour search core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package npcs_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int COLOR_W     = 12;
	localparam int NIB_W       = 4;
	localparam int CHAN_W      = 8;
	localparam int SQ_W        = 2 * NIB_W;
	localparam int DIST_W      = 15;

	localparam logic [DIST_W-1:0] W_RED   = DIST_W'(30);
	localparam logic [DIST_W-1:0] W_GREEN = DIST_W'(59);
	localparam logic [DIST_W-1:0] W_BLUE  = DIST_W'(11);
	// above any reachable distance (max 22500)
	localparam logic [DIST_W-1:0] NO_DIST = '1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] idx;
	} tag_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] idx;
		logic [DIST_W-1:0] distance;
	} dist_res_t;

	typedef struct packed {
		logic [NIB_W-1:0] r;
		logic [NIB_W-1:0] g;
		logic [NIB_W-1:0] b;
	} rgb4_t;

endpackage

### rtl/core/nearest_palette_color_search_core.sv
// Top level of the nearest palette colour search: control FSM, scan counter, best-match tracker.
// Depends on npcs_pkg, npcs_pal_ram and npcs_dist_pipe.
`timescale 1ns / 1ps

// Nearest palette colour search core.
// Input channel (in_valid/in_ready): one word is either a palette write (cmd = write:
// entry_colour stored at entry_index, no result) or a query (cmd = query: 8-bit RGB,
// top nibble of each channel used).
// Output channel (out_valid/out_ready): one best_index word per query, the active
// palette entry with least 30*dr^2 + 59*dg^2 + 11*db^2, lowest index on ties, 0 if
// no entries are active.
// cfg_wr_en/cfg_wr_data set active_colors (values above 64 act as 64); write only when idle.
// A write is taken in the idle state and needs no scan. A query reads the palette RAM one
// entry per cycle through its single read port, then drains a three-deep distance pipe; the
// next word is accepted only after the drain state has loaded the result into the output
// register, which drives out_valid.
// Reset clears the FSM, pipe valids, output valid and active_colors; palette contents
// are undefined until written, and no entry may be searched before it is written.
// A result waits in the output register while the receiver stalls; the next word is
// still accepted, but a following query cannot publish its result until the old one
// is taken, and the core holds that query in the drain state meanwhile.
module nearest_palette_color_search_core
	import npcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [ADDR_W-1:0]  entry_index,
	input  logic [COLOR_W-1:0] entry_color,
	input  logic [CHAN_W-1:0]  query_red,
	input  logic [CHAN_W-1:0]  query_green,
	input  logic [CHAN_W-1:0]  query_blue,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ADDR_W-1:0]  best_index,
	input  logic               cfg_wr_en,
	input  logic [CNT_W-1:0]   cfg_wr_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  active_colors_q;
	logic [CNT_W-1:0]  count_sat;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  iss_q;
	rgb4_t             query_q;

	logic              in_acc;
	logic              wr_en;
	logic              qry_acc;
	logic              rd_en;
	logic              last_issue;
	logic              pipe_busy;
	logic              load_out;

	tag_t              tag_s1;
	logic [COLOR_W-1:0] entry_s1;
	logic              dist_busy;
	dist_res_t         res_s3;

	logic [DIST_W-1:0] best_dist_q;
	logic [ADDR_W-1:0] best_idx_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] best_index_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_colors_q <= '0;
		end else if (cfg_wr_en) begin
			active_colors_q <= cfg_wr_data;
		end
	end

	assign count_sat = (active_colors_q > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
	                                                            : active_colors_q;

	assign in_acc  = in_valid & in_ready;
	assign wr_en   = in_acc & (cmd == CMD_WRITE);
	assign qry_acc = in_acc & (cmd == CMD_QUERY);

	assign last_issue = (iss_q + CNT_W'(1)) == count_q;
	assign pipe_busy  = tag_s1.valid | dist_busy;

	// FSM: next state and strobes
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && cmd == CMD_QUERY) begin
					// empty palette goes straight to publish with index 0
					state_d = (count_sat == '0) ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// best is final once the pipe is empty; wait for a free output slot
				if (!pipe_busy && (!out_valid_q || out_ready)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// query context and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q   <= '0;
			count_q <= '0;
		end else if (qry_acc) begin
			iss_q   <= '0;
			count_q <= count_sat;
		end else if (rd_en) begin
			iss_q <= iss_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (qry_acc) begin
			query_q.r <= query_red[CHAN_W-1 -: NIB_W];
			query_q.g <= query_green[CHAN_W-1 -: NIB_W];
			query_q.b <= query_blue[CHAN_W-1 -: NIB_W];
		end
	end

	npcs_pal_ram u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (entry_index),
		.wdata (entry_color),
		.re    (rd_en),
		.raddr (iss_q[ADDR_W-1:0]),
		.rdata (entry_s1)
	);

	// tag follows the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= rd_en;
			tag_s1.idx   <= iss_q[ADDR_W-1:0];
		end
	end

	npcs_dist_pipe u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.query    (query_q),
		.tag_s1   (tag_s1),
		.entry_s1 (entry_s1),
		.busy     (dist_busy),
		.res_s3   (res_s3)
	);

	// running minimum; strict less-than keeps the lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= NO_DIST;
			best_idx_q  <= '0;
		end else if (qry_acc) begin
			best_dist_q <= NO_DIST;
			best_idx_q  <= '0;
		end else if (res_s3.valid && res_s3.distance < best_dist_q) begin
			best_dist_q <= res_s3.distance;
			best_idx_q  <= res_s3.idx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			best_index_q <= best_idx_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_index = best_index_q;

`ifndef SYNTHESIS
	// reads stay inside the searched range
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (iss_q < count_q))
		else $error("palette read beyond active range");

	// a result is only published once the distance pipe has emptied
	a_load_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !tag_s1.valid && !res_s3.valid)
		else $error("result published with pipe still busy");

	// published index lies within the searched entries
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (count_q == '0 && best_index == '0) ||
			(CNT_W'(best_index) < count_q))
		else $error("best index outside searched range");

	// no distance results arrive outside a query
	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_s3.valid |-> (state_q == ST_SCAN) || (state_q == ST_DRAIN))
		else $error("distance result outside a scan");
`endif

endmodule

### rtl/core/npcs_pal_ram.sv
// Palette store: single write port, single registered read port.
// Depends on npcs_pkg.
`timescale 1ns / 1ps

module npcs_pal_ram
	import npcs_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [COLOR_W-1:0] wdata,
	input  logic               re,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [COLOR_W-1:0] rdata
);

	logic [COLOR_W-1:0] mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/npcs_dist_pipe.sv
// Two-stage weighted RGB444 distance pipe: squared channel deltas, then weighted sum.
// Depends on npcs_pkg.
`timescale 1ns / 1ps

module npcs_dist_pipe
	import npcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  rgb4_t              query,
	input  tag_t               tag_s1,
	input  logic [COLOR_W-1:0] entry_s1,
	output logic               busy,
	output dist_res_t          res_s3
);

	tag_t            tag_s2;
	logic [SQ_W-1:0] sq_r_s2, sq_g_s2, sq_b_s2;
	logic [NIB_W-1:0] dr, dg, db;
	logic [NIB_W-1:0] er, eg, eb;
	logic [DIST_W-1:0] dist_sum;

	assign er = entry_s1[3*NIB_W-1:2*NIB_W];
	assign eg = entry_s1[2*NIB_W-1:NIB_W];
	assign eb = entry_s1[NIB_W-1:0];

	assign dr = (query.r > er) ? (query.r - er) : (er - query.r);
	assign dg = (query.g > eg) ? (query.g - eg) : (eg - query.g);
	assign db = (query.b > eb) ? (query.b - eb) : (eb - query.b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2.valid <= tag_s1.valid;
			tag_s2.idx   <= tag_s1.idx;
		end
	end

	always_ff @(posedge clk) begin
		sq_r_s2    <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s2    <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s2    <= SQ_W'(db) * SQ_W'(db);
	end

	assign dist_sum = DIST_W'(sq_r_s2) * W_RED
	                + DIST_W'(sq_g_s2) * W_GREEN
	                + DIST_W'(sq_b_s2) * W_BLUE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3 <= '0;
		end else begin
			res_s3.valid    <= tag_s2.valid;
			res_s3.idx      <= tag_s2.idx;
			res_s3.distance <= dist_sum;
		end
	end

	assign busy = tag_s2.valid | res_s3.valid;

endmodule

### dv/testbench.sv
// Self-checking bench for nearest_palette_color_search_core: palette writes and nearest-colour
// queries are driven over valid/ready, and each best_index word is checked against an in-bench
// predictor. Depends on npcs_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
	import npcs_pkg::*;

	localparam int STALL_PCT     = 38;   // chance in a hundred that a side stalls at each roll
	localparam int SETTLE_CYCLES = 80;   // worst-case scan (64 entries) plus the drain pipe
	localparam int IDLE_LIMIT    = 4000; // cycles with no handshake before giving up
	localparam int PHASE_WORDS   = 90;

	// Tracks the palette and the active count, predicts best_index for every accepted
	// query and holds the predictions until the matching result word turns up.
	class palette_scoreboard;
		logic [COLOR_W-1:0] palette [MAX_ENTRIES];
		int unsigned        searched;
		logic [ADDR_W-1:0]  due_index [$];
		int unsigned        errors;
		int unsigned        writes;
		int unsigned        queries;

		function new();
			searched = 0;
			errors   = 0;
			writes   = 0;
			queries  = 0;
			foreach (palette[j])
				palette[j] = '0;
		endfunction

		// Weighted squared distance scan; strict less-than keeps the lowest index on ties.
		function logic [ADDR_W-1:0] nearest(rgb4_t q);
			int unsigned       span;
			int unsigned       wdist;
			int unsigned       best_dist;
			int unsigned       dr, dg, db;
			logic [ADDR_W-1:0] best;
			rgb4_t             e;
			span      = (searched > MAX_ENTRIES) ? MAX_ENTRIES : searched;
			best      = '0;
			best_dist = 32'h7FFF_FFFF;
			for (int j = 0; j < span; j++) begin
				e  = palette[j];
				dr = (q.r > e.r) ? q.r - e.r : e.r - q.r;
				dg = (q.g > e.g) ? q.g - e.g : e.g - q.g;
				db = (q.b > e.b) ? q.b - e.b : e.b - q.b;
				wdist = int'(W_RED) * dr * dr + int'(W_GREEN) * dg * dg + int'(W_BLUE) * db * db;
				if (wdist < best_dist) begin
					best_dist = wdist;
					best      = ADDR_W'(j);
				end
			end
			return best;
		endfunction

		function void note_word(logic c, logic [ADDR_W-1:0] idx, logic [COLOR_W-1:0] colour,
				rgb4_t q);
			if (c == CMD_WRITE) begin
				palette[idx] = colour;
				writes++;
			end else begin
				due_index.push_back(nearest(q));
				queries++;
			end
		endfunction

		function void check_result(logic [ADDR_W-1:0] got);
			logic [ADDR_W-1:0] want;
			if (due_index.size() == 0) begin
				errors++;
				$display("%0t: best_index %0d arrived with no query outstanding", $time, got);
			end else begin
				want = due_index.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: best_index expected %0d, actual %0d", $time, want, got);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic [ADDR_W-1:0]  entry_index;
	logic [COLOR_W-1:0] entry_color;
	logic [CHAN_W-1:0]  query_red;
	logic [CHAN_W-1:0]  query_green;
	logic [CHAN_W-1:0]  query_blue;
	logic               out_valid;
	logic               out_ready;
	logic [ADDR_W-1:0]  best_index;
	logic               cfg_wr_en;
	logic [CNT_W-1:0]   cfg_wr_data;

	palette_scoreboard     sb = new();
	bit                    calm;          // when set neither side idles
	bit [MAX_ENTRIES-1:0]  written;       // slots loaded so far; only these may be searched
	int unsigned           idle_cycles;
	int unsigned           settings_seen;
	int unsigned           plan [12] = '{1, 64, 127, 0, 65, 2, 33, 100, 16, 64, 5, 127};

	nearest_palette_color_search_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.entry_index (entry_index),
		.entry_color (entry_color),
		.query_red   (query_red),
		.query_green (query_green),
		.query_blue  (query_blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.best_index  (best_index),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: ready toggles at random on the falling edge, independent of out_valid.
	always @(negedge clk) begin
		out_ready = calm || ($urandom_range(99) >= STALL_PCT);
	end

	// Monitor and watchdog. Results are checked before a new query is noted so that a
	// stray result word can never be matched against a prediction made at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(best_index);
			if (in_valid && in_ready)
				sb.note_word(cmd, entry_index, entry_color,
					rgb4_t'{query_red[7:4], query_green[7:4], query_blue[7:4]});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// One word on the input channel. Entered just after a rising edge; fields change on the
	// falling edge, and the task returns right after the edge that takes the word.
	task automatic send_word(logic c, logic [ADDR_W-1:0] idx, logic [COLOR_W-1:0] colour,
			logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
		@(negedge clk);
		while (!calm && $urandom_range(99) < STALL_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		cmd         = c;
		entry_index = idx;
		entry_color = colour;
		query_red   = r;
		query_green = g;
		query_blue  = b;
		if (c == CMD_WRITE)
			written[idx] = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid, let every outstanding result come back, then give a trailing write time
	// to land in the RAM before anything else changes.
	task automatic drain_and_settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.due_index.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_count(int unsigned v);
		drain_and_settle();
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = CNT_W'(v);
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		sb.searched = v;
		settings_seen++;
	endtask

	// Load every slot that the new count will search and that still holds nothing.
	task automatic fill_searched(int unsigned v);
		int unsigned span;
		span = (v > MAX_ENTRIES) ? MAX_ENTRIES : v;
		for (int j = 0; j < span; j++)
			if (!written[j])
				send_word(CMD_WRITE, ADDR_W'(j), COLOR_W'($urandom()), CHAN_W'($urandom()),
					CHAN_W'($urandom()), CHAN_W'($urandom()));
	endtask

	// Mix: about a third writes (some copying a searched colour to force ties), the rest
	// queries, half of them aimed at a searched entry with random low nibbles.
	task automatic random_word();
		int unsigned        roll;
		int unsigned        span;
		logic [COLOR_W-1:0] colour;
		rgb4_t              aim;
		roll = $urandom_range(99);
		span = (sb.searched > MAX_ENTRIES) ? MAX_ENTRIES : sb.searched;
		if (roll < 35) begin
			colour = COLOR_W'($urandom());
			if (roll < 9 && span != 0)
				colour = sb.palette[$urandom_range(span - 1)];
			send_word(CMD_WRITE, ADDR_W'($urandom()), colour, CHAN_W'($urandom()),
				CHAN_W'($urandom()), CHAN_W'($urandom()));
		end else if (roll < 68 && span != 0) begin
			aim = sb.palette[$urandom_range(span - 1)];
			send_word(CMD_QUERY, ADDR_W'($urandom()), COLOR_W'($urandom()),
				{aim.r, 4'($urandom())}, {aim.g, 4'($urandom())}, {aim.b, 4'($urandom())});
		end else begin
			send_word(CMD_QUERY, ADDR_W'($urandom()), COLOR_W'($urandom()),
				CHAN_W'($urandom()), CHAN_W'($urandom()), CHAN_W'($urandom()));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = CMD_WRITE;
		entry_index   = '0;
		entry_color   = '0;
		query_red     = '0;
		query_green   = '0;
		query_blue    = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		calm          = 1'b0;
		written       = '0;
		idle_cycles   = 0;
		settings_seen = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: count still zero out of reset, so both queries must give index 0.
		send_word(CMD_QUERY, '1, '1, 8'hFF, 8'hFF, 8'hFF);
		send_word(CMD_QUERY, '0, '0, 8'h00, 8'h00, 8'h00);
		// White, two identical blacks (tie), a mid colour, and the top slot left unsearched.
		send_word(CMD_WRITE, 6'd0, 12'hFFF, 8'h00, 8'h00, 8'h00);
		send_word(CMD_WRITE, 6'd1, 12'h000, 8'hFF, 8'hFF, 8'hFF);
		send_word(CMD_WRITE, 6'd2, 12'h000, 8'h00, 8'h00, 8'h00);
		send_word(CMD_WRITE, 6'd3, 12'h84C, 8'h00, 8'h00, 8'h00);
		send_word(CMD_WRITE, 6'd63, 12'hA5F, 8'h00, 8'h00, 8'h00);
		program_count(4);
		send_word(CMD_QUERY, '0, '0, 8'h0F, 8'h0F, 8'h0F);   // tie between 1 and 2
		send_word(CMD_QUERY, '0, '0, 8'hFF, 8'hFF, 8'hFF);
		send_word(CMD_QUERY, '0, '0, 8'h80, 8'h40, 8'hC0);   // exact hit on slot 3
		send_word(CMD_QUERY, '1, '1, 8'h8F, 8'h4F, 8'hCF);   // low nibbles must be ignored
		send_word(CMD_QUERY, '0, '0, 8'h00, 8'hF0, 8'h00);   // green weight decides
		send_word(CMD_QUERY, '0, '0, 8'hA0, 8'h50, 8'hF0);   // slot 63 must not be picked

		// Random phases over a spread of counts: zero, one, full, and saturating values.
		// Each count change waits for the core to drain first.
		foreach (plan[p]) begin
			program_count(plan[p]);
			calm = (p == 4);
			fill_searched(plan[p]);
			repeat (PHASE_WORDS) random_word();
			calm = 1'b0;
		end

		drain_and_settle();
		$display("Covered %0d palette writes and %0d queries under %0d active-count settings,",
			sb.writes, sb.queries, settings_seen);
		$display("from an empty search through the full palette and counts above 64.");
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
rtl/core/npcs_pkg.sv
rtl/core/npcs_pal_ram.sv
rtl/core/npcs_dist_pipe.sv
rtl/core/nearest_palette_color_search_core.sv
dv/testbench.sv
